FILE: hdl/joystick_polar_direction_assert.svh
// Assertion macros for the joystick polar direction block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef JOYSTICK_POLAR_DIRECTION_ASSERT_SVH
`define JOYSTICK_POLAR_DIRECTION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JPD_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JPD_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: hdl/jpd_pkg.sv
// Shared types, constants and functions of the joystick polar direction block.
// No dependencies; all other files but the assert header use its scoped names.
package jpd_pkg;

	localparam int ADC_BITS_DEF      = 12;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int QUEUE_DEPTH       = 4;

	localparam int CFG_W    = 12;
	localparam int DZ_W     = 16;
	localparam int AXIS_W   = 13;
	localparam int AXIS_LIM = 2048;
	localparam int ROOT_W   = 16;
	localparam int RAD_W    = 32;
	localparam int REM_W    = 20;
	localparam int PROD_W   = 30;
	localparam int MAP_W    = 17;
	localparam int FRAC_SH  = 11;
	localparam int GUARD    = 8;
	localparam int CORD_W   = 28;
	localparam int ANG_W    = 28;
	localparam int ANGU_W   = 25;
	localparam int XMAG_W   = 27;
	localparam int XLO_W    = 14;
	localparam int GAIN_W   = 30;
	localparam int MAG_W    = 16;
	localparam int HEAD_W   = 16;
	localparam int DIR_W    = 3;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [GAIN_W-1:0]        INV_GAIN   = 30'd652032874;
	localparam logic signed [ANG_W-1:0]  ANGLE_FULL = 28'sd23592960;
	localparam logic signed [ANG_W-1:0]  ANGLE_HALF = 28'sd11796480;
	localparam logic [MAG_W-1:0]         MAG_MAX    = 16'd32768;
	localparam logic [HEAD_W-1:0]        HEAD_MAX   = 16'd35999;
	localparam logic [HEAD_W-1:0]        SECTOR_NE  = 16'd4500;
	localparam logic [HEAD_W-1:0]        SECTOR_SE  = 16'd13500;
	localparam logic [HEAD_W-1:0]        SECTOR_SW  = 16'd22500;
	localparam logic [HEAD_W-1:0]        SECTOR_NW  = 16'd31500;

	localparam logic [CFG_W-1:0] CENTRE_RESET = 12'd2048;
	localparam logic [DZ_W-1:0]  DZ_RESET     = 16'd3277;

	typedef enum logic [1:0] {
		REG_CENTRE_H  = 2'd0,
		REG_CENTRE_V  = 2'd1,
		REG_DEAD_ZONE = 2'd2
	} reg_idx_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_CENTRE = 3'd0,
		DIR_UP     = 3'd1,
		DIR_RIGHT  = 3'd2,
		DIR_DOWN   = 3'd3,
		DIR_LEFT   = 3'd4
	} dir_t;

	typedef struct packed {
		logic [CFG_W-1:0] centre_horizontal;
		logic [CFG_W-1:0] centre_vertical;
		logic [DZ_W-1:0]  dead_zone;
	} cfg_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] east;
		logic signed [AXIS_W-1:0] north;
	} axis_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} root_t;

	// One digit of a restoring square root: two radicand bits in, one root bit out.
	function automatic root_t root_step(input root_t cur);
		logic [REM_W-1:0] cand;
		logic [REM_W-1:0] test;
		root_t nxt;
		cand = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
		test = {2'b00, cur.root, 2'b01};
		nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
		if (cand >= test) begin
			nxt.rem  = cand - test;
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = cand;
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// atan(2^-i) in units of 1/65536 degree, rounded to nearest.
	function automatic logic [21:0] atan_q16(input int i);
		logic [21:0] a;
		case (i)
			0: a = 22'd2949120;
			1: a = 22'd1740967;
			2: a = 22'd919879;
			3: a = 22'd466945;
			4: a = 22'd234379;
			5: a = 22'd117304;
			6: a = 22'd58666;
			7: a = 22'd29335;
			8: a = 22'd14668;
			9: a = 22'd7334;
			10: a = 22'd3667;
			11: a = 22'd1833;
			12: a = 22'd917;
			13: a = 22'd458;
			14: a = 22'd229;
			15: a = 22'd115;
			16: a = 22'd57;
			17: a = 22'd29;
			18: a = 22'd14;
			19: a = 22'd7;
			20: a = 22'd4;
			21: a = 22'd2;
			22: a = 22'd1;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

FILE: hdl/jpd_sample_if.sv
// Input channel: one pair of raw joystick ADC readings per transaction.
// Width follows the ADC resolution given at instantiation.
interface jpd_sample_if #(parameter int ADC_BITS = jpd_pkg::ADC_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] horizontal_sample;
	logic [ADC_BITS-1:0] vertical_sample;

	modport source (output valid, output horizontal_sample, output vertical_sample,
		input ready);
	modport sink (input valid, input horizontal_sample, input vertical_sample,
		output ready);
endinterface

FILE: hdl/jpd_result_if.sv
// Output channel: one compass reading per transaction.
// Field widths come from jpd_pkg.
interface jpd_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [jpd_pkg::MAP_W-1:0]   east_mapped;
	logic signed [jpd_pkg::MAP_W-1:0]   north_mapped;
	logic [jpd_pkg::MAG_W-1:0]          magnitude;
	logic [jpd_pkg::HEAD_W-1:0]         heading;
	logic                               centred;
	logic [jpd_pkg::DIR_W-1:0]          direction;

	modport source (output valid, output east_mapped, output north_mapped,
		output magnitude, output heading, output centred, output direction,
		input ready);
	modport sink (input valid, input east_mapped, input north_mapped,
		input magnitude, input heading, input centred, input direction,
		output ready);
endinterface

FILE: hdl/joystick_polar_direction.sv
// Channel      Dir  Contents
// sample_in    in   horizontal_sample, vertical_sample (raw ADC readings)
// result_out   out  east/north mapped, magnitude, heading, centred, direction
// apb          in   centre_horizontal @0x0, centre_vertical @0x4, dead_zone @0x8
//
// One transaction is accepted per cycle while the queue has room; the pipeline
// holds the sixteen square-root digit stages and one CORDIC stage per rotation.
// Reset is asynchronous and active low; it clears all valid flags and loads the
// register defaults. An output stall holds the whole back end, while the queue
// lets the front end keep taking samples until it fills.
//
// Top level of the joystick polar direction block. Depends on jpd_pkg, both
// channel interfaces, jpd_front, jpd_queue, jpd_circle_map and jpd_cordic.
`include "joystick_polar_direction_assert.svh"

module joystick_polar_direction #(
	parameter int ADC_BITS      = jpd_pkg::ADC_BITS_DEF,
	parameter int CORDIC_STAGES = jpd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	jpd_sample_if.sink                   sample_in,
	jpd_result_if.source                 result_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [jpd_pkg::ADDR_W-1:0]   paddr,
	input  logic [jpd_pkg::DATA_W-1:0]   pwdata,
	output logic [jpd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	logic [jpd_pkg::CFG_W-1:0] centre_h_q;
	logic [jpd_pkg::CFG_W-1:0] centre_v_q;
	logic [jpd_pkg::DZ_W-1:0]  dead_zone_q;
	jpd_pkg::reg_idx_t         reg_idx;
	logic                      cfg_write;
	jpd_pkg::cfg_t             cfg;

	logic                      front_valid;
	logic                      front_ready;
	jpd_pkg::axis_t            front_item;
	logic                      queue_valid;
	jpd_pkg::axis_t            queue_item;
	logic                      adv;
	logic                      map_valid;
	logic signed [jpd_pkg::MAP_W-1:0] east_mapped;
	logic signed [jpd_pkg::MAP_W-1:0] north_mapped;

	assign pready    = 1'b1;
	assign reg_idx   = jpd_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_h_q  <= jpd_pkg::CENTRE_RESET;
			centre_v_q  <= jpd_pkg::CENTRE_RESET;
			dead_zone_q <= jpd_pkg::DZ_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				jpd_pkg::REG_CENTRE_H:  centre_h_q  <= pwdata[jpd_pkg::CFG_W-1:0];
				jpd_pkg::REG_CENTRE_V:  centre_v_q  <= pwdata[jpd_pkg::CFG_W-1:0];
				jpd_pkg::REG_DEAD_ZONE: dead_zone_q <= pwdata[jpd_pkg::DZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			jpd_pkg::REG_CENTRE_H:  prdata = jpd_pkg::DATA_W'(centre_h_q);
			jpd_pkg::REG_CENTRE_V:  prdata = jpd_pkg::DATA_W'(centre_v_q);
			jpd_pkg::REG_DEAD_ZONE: prdata = jpd_pkg::DATA_W'(dead_zone_q);
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		cfg.centre_horizontal = centre_h_q;
		cfg.centre_vertical   = centre_v_q;
		cfg.dead_zone         = dead_zone_q;
	end

	jpd_front #(
		.ADC_BITS (ADC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.cfg        (cfg),
		.item_valid (front_valid),
		.item       (front_item),
		.item_ready (front_ready)
	);

	jpd_queue #(
		.DEPTH (jpd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_data  (front_item),
		.push_ready (front_ready),
		.pop_valid  (queue_valid),
		.pop_data   (queue_item),
		.pop_ready  (adv)
	);

	jpd_circle_map u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (queue_valid),
		.in_item      (queue_item),
		.out_valid    (map_valid),
		.east_mapped  (east_mapped),
		.north_mapped (north_mapped)
	);

	jpd_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.dead_zone  (cfg.dead_zone),
		.in_valid   (map_valid),
		.east_in    (east_mapped),
		.north_in   (north_mapped),
		.adv        (adv),
		.result_out (result_out)
	);

	`JPD_ASSERT_NOW(a_centred_clears, result_out.valid && result_out.centred, result_out.magnitude == '0 && result_out.heading == '0 && result_out.direction == jpd_pkg::DIR_CENTRE, "centred result carries a non-zero reading")
	`JPD_ASSERT_NOW(a_live_reading, result_out.valid && !result_out.centred, result_out.direction != jpd_pkg::DIR_CENTRE && result_out.heading <= jpd_pkg::HEAD_MAX && result_out.magnitude >= dead_zone_q, "uncentred result is inconsistent")
	`JPD_ASSERT_NEXT(a_dead_zone_write, cfg_write && reg_idx == jpd_pkg::REG_DEAD_ZONE, dead_zone_q == $past(pwdata[jpd_pkg::DZ_W-1:0]), "dead zone register missed a write")
endmodule

FILE: hdl/jpd_front.sv
// Front end: accepts sample pairs, removes the calibrated centre, scales to
// Q1.11 and saturates. Depends on jpd_pkg and jpd_sample_if.
module jpd_front #(
	parameter int ADC_BITS = jpd_pkg::ADC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	jpd_sample_if.sink        sample_in,
	input  jpd_pkg::cfg_t     cfg,
	output logic              item_valid,
	output jpd_pkg::axis_t    item,
	input  logic              item_ready
);
	localparam int DW = ((ADC_BITS > 12) ? ADC_BITS : 12) + 2;
	localparam int UP = (ADC_BITS < 12) ? (12 - ADC_BITS) : 0;
	localparam int DN = (ADC_BITS > 12) ? (ADC_BITS - 12) : 0;
	localparam logic signed [DW-1:0] LIM_P = DW'(jpd_pkg::AXIS_LIM);
	localparam logic signed [DW-1:0] LIM_N = -LIM_P;

	function automatic logic signed [jpd_pkg::AXIS_W-1:0] to_axis(
		input logic [ADC_BITS-1:0] smp,
		input logic [ADC_BITS-1:0] ctr
	);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] q;
		d = $signed(DW'(smp)) - $signed(DW'(ctr));
		// Wide converters drop low bits with truncation toward zero.
		if (d < 0) begin
			q = -((-d) >>> DN);
		end else begin
			q = d >>> DN;
		end
		q = q <<< UP;
		if (q > LIM_P) begin
			q = LIM_P;
		end else if (q < LIM_N) begin
			q = LIM_N;
		end
		return jpd_pkg::AXIS_W'(q);
	endfunction

	logic [ADC_BITS-1:0] ctr_h;
	logic [ADC_BITS-1:0] ctr_v;
	jpd_pkg::axis_t      nxt;
	logic                accept;
	logic                valid_s1;
	jpd_pkg::axis_t      item_s1;

	assign ctr_h = ADC_BITS'(cfg.centre_horizontal);
	assign ctr_v = ADC_BITS'(cfg.centre_vertical);

	always_comb begin
		nxt.east  = -to_axis(sample_in.horizontal_sample, ctr_h);
		nxt.north = to_axis(sample_in.vertical_sample, ctr_v);
	end

	assign sample_in.ready = !valid_s1 || item_ready;
	assign accept          = sample_in.valid && sample_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= nxt;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;
endmodule

FILE: hdl/jpd_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on jpd_pkg for the item type.
module jpd_queue #(
	parameter int DEPTH = jpd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  jpd_pkg::axis_t push_data,
	output logic           push_ready,
	output logic           pop_valid,
	output jpd_pkg::axis_t pop_data,
	input  logic           pop_ready
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jpd_pkg::axis_t mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule

FILE: hdl/jpd_circle_map.sv
// Square-to-circle mapping: pipelined square roots of 1 - v^2/2, then the
// scaling multiply with truncation toward zero. Depends on jpd_pkg.
module jpd_circle_map (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  jpd_pkg::axis_t                   in_item,
	output logic                             out_valid,
	output logic signed [jpd_pkg::MAP_W-1:0] east_mapped,
	output logic signed [jpd_pkg::MAP_W-1:0] north_mapped
);
	localparam int NS = jpd_pkg::ROOT_W;

	logic                                 vld_s  [NS+1];
	jpd_pkg::root_t                       re_s   [NS+1];
	jpd_pkg::root_t                       rn_s   [NS+1];
	jpd_pkg::axis_t                       ax_s   [NS+1];

	logic signed [2*jpd_pkg::AXIS_W-1:0] sq_e;
	logic signed [2*jpd_pkg::AXIS_W-1:0] sq_n;
	logic [23:0]                          t_e;
	logic [23:0]                          t_n;
	jpd_pkg::root_t                       re_0;
	jpd_pkg::root_t                       rn_0;

	logic                                 vld_m;
	logic signed [jpd_pkg::PROD_W-1:0]   pe_m;
	logic signed [jpd_pkg::PROD_W-1:0]   pn_m;
	logic                                 vld_o;
	logic signed [jpd_pkg::MAP_W-1:0]    east_o;
	logic signed [jpd_pkg::MAP_W-1:0]    north_o;

	function automatic logic signed [jpd_pkg::MAP_W-1:0] trunc_q11(
		input logic signed [jpd_pkg::PROD_W-1:0] p
	);
		logic signed [jpd_pkg::PROD_W-1:0] r;
		if (p < 0) begin
			r = (p + jpd_pkg::PROD_W'(2047)) >>> jpd_pkg::FRAC_SH;
		end else begin
			r = p >>> jpd_pkg::FRAC_SH;
		end
		return jpd_pkg::MAP_W'(r);
	endfunction

	// The east factor is taken from the north axis and vice versa.
	always_comb begin
		sq_n = in_item.north * in_item.north;
		sq_e = in_item.east * in_item.east;
		t_e  = 24'h800000 - 24'(sq_n);
		t_n  = 24'h800000 - 24'(sq_e);
		re_0.rem  = '0;
		re_0.root = '0;
		re_0.rad  = jpd_pkg::RAD_W'({t_e, 7'b0000000});
		rn_0.rem  = '0;
		rn_0.root = '0;
		rn_0.rad  = jpd_pkg::RAD_W'({t_n, 7'b0000000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_s[0] <= re_0;
			rn_s[0] <= rn_0;
			ax_s[0] <= in_item;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				re_s[k+1] <= jpd_pkg::root_step(re_s[k]);
				rn_s[k+1] <= jpd_pkg::root_step(rn_s[k]);
				ax_s[k+1] <= ax_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m <= 1'b0;
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_m <= vld_s[NS];
			vld_o <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pe_m    <= ax_s[NS].east * $signed({1'b0, re_s[NS].root});
			pn_m    <= ax_s[NS].north * $signed({1'b0, rn_s[NS].root});
			east_o  <= trunc_q11(pe_m);
			north_o <= trunc_q11(pn_m);
		end
	end

	assign out_valid    = vld_o;
	assign east_mapped  = east_o;
	assign north_mapped = north_o;
endmodule

FILE: hdl/jpd_cordic.sv
// Vectoring CORDIC, one micro-rotation per stage, then gain correction,
// heading scaling, dead zone and sector decode into the output register.
// Depends on jpd_pkg and jpd_result_if.
module jpd_cordic #(
	parameter int CORDIC_STAGES = jpd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [jpd_pkg::DZ_W-1:0]         dead_zone,
	input  logic                             in_valid,
	input  logic signed [jpd_pkg::MAP_W-1:0] east_in,
	input  logic signed [jpd_pkg::MAP_W-1:0] north_in,
	output logic                             adv,
	jpd_result_if.source                     result_out
);
	localparam int NS = CORDIC_STAGES;
	localparam int CW = jpd_pkg::CORD_W;
	localparam int AW = jpd_pkg::ANG_W;
	localparam int MW = jpd_pkg::MAP_W;
	localparam int SUM_W = jpd_pkg::XMAG_W + jpd_pkg::GAIN_W;
	localparam int PH_W  = (jpd_pkg::XMAG_W - jpd_pkg::XLO_W) + jpd_pkg::GAIN_W;
	localparam int PL_W  = jpd_pkg::XLO_W + jpd_pkg::GAIN_W;
	localparam int MSH   = 30 + jpd_pkg::GUARD;

	logic                 vld_c   [NS+1];
	logic signed [CW-1:0] x_c     [NS+1];
	logic signed [CW-1:0] y_c     [NS+1];
	logic signed [AW-1:0] z_c     [NS+1];
	logic                 zero_c  [NS+1];
	logic signed [MW-1:0] east_c  [NS+1];
	logic signed [MW-1:0] north_c [NS+1];

	logic signed [CW-1:0] x0;
	logic signed [CW-1:0] y0;

	// Post-processing stages
	logic                           vld_p1, vld_p2, vld_p3, vld_p4;
	logic [jpd_pkg::XMAG_W-1:0]     xmag_p1;
	logic [jpd_pkg::ANGU_W-1:0]     ang_p1;
	logic signed [MW-1:0]           east_p1, east_p2, east_p3, east_p4;
	logic signed [MW-1:0]           north_p1, north_p2, north_p3, north_p4;
	logic signed [AW-1:0]           zw;
	logic [PH_W-1:0]                ph_p2;
	logic [PL_W-1:0]                pl_p2;
	logic [31:0]                    hd_p2;
	logic [SUM_W-1:0]               sum;
	logic [SUM_W-MSH-1:0]           mag_raw;
	logic [jpd_pkg::HEAD_W-1:0]     hd_raw;
	logic [jpd_pkg::MAG_W-1:0]      mag_p3;
	logic [jpd_pkg::HEAD_W-1:0]     head_p3;
	logic [jpd_pkg::MAG_W-1:0]      mag_p4;
	logic [jpd_pkg::HEAD_W-1:0]     head_p4;
	logic                           cen_p4;
	jpd_pkg::dir_t                  dir_p4;
	jpd_pkg::dir_t                  dir_nxt;
	logic                           cen_nxt;

	assign adv = !result_out.valid || result_out.ready;

	assign x0 = CW'(north_in) <<< jpd_pkg::GUARD;
	assign y0 = CW'(east_in) <<< jpd_pkg::GUARD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (adv) begin
			vld_c[0] <= in_valid;
		end
	end

	// Points in the southern half are turned through 180 degrees first.
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_c[0]  <= (x0 == '0) && (y0 == '0);
			east_c[0]  <= east_in;
			north_c[0] <= north_in;
			if (x0 < 0) begin
				x_c[0] <= -x0;
				y_c[0] <= -y0;
				z_c[0] <= jpd_pkg::ANGLE_HALF;
			end else begin
				x_c[0] <= x0;
				y_c[0] <= y0;
				z_c[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam logic signed [AW-1:0] ATAN = $signed(AW'(jpd_pkg::atan_q16(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[i+1] <= 1'b0;
			end else if (adv) begin
				vld_c[i+1] <= vld_c[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_c[i+1]  <= zero_c[i];
				east_c[i+1]  <= east_c[i];
				north_c[i+1] <= north_c[i];
				if (y_c[i] >= 0) begin
					x_c[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] + ATAN;
				end else begin
					x_c[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] - ATAN;
				end
			end
		end
	end

	// The origin reads as north whatever the rotations did to the angle.
	always_comb begin
		if (zero_c[NS]) begin
			zw = '0;
		end else if (z_c[NS] < 0) begin
			zw = z_c[NS] + jpd_pkg::ANGLE_FULL;
		end else if (z_c[NS] >= jpd_pkg::ANGLE_FULL) begin
			zw = z_c[NS] - jpd_pkg::ANGLE_FULL;
		end else begin
			zw = z_c[NS];
		end
	end

	always_comb begin
		sum     = {ph_p2, jpd_pkg::XLO_W'(0)} + SUM_W'(pl_p2);
		mag_raw = sum[SUM_W-1:MSH];
		hd_raw  = hd_p2[31:16];
	end

	always_comb begin
		cen_nxt = (mag_p3 < dead_zone);
		if (cen_nxt) begin
			dir_nxt = jpd_pkg::DIR_CENTRE;
		end else if (head_p3 < jpd_pkg::SECTOR_NE) begin
			dir_nxt = jpd_pkg::DIR_UP;
		end else if (head_p3 < jpd_pkg::SECTOR_SE) begin
			dir_nxt = jpd_pkg::DIR_RIGHT;
		end else if (head_p3 < jpd_pkg::SECTOR_SW) begin
			dir_nxt = jpd_pkg::DIR_DOWN;
		end else if (head_p3 < jpd_pkg::SECTOR_NW) begin
			dir_nxt = jpd_pkg::DIR_LEFT;
		end else begin
			dir_nxt = jpd_pkg::DIR_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
		end else if (adv) begin
			vld_p1 <= vld_c[NS];
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			vld_p4 <= vld_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xmag_p1  <= (x_c[NS] < 0) ? '0 : x_c[NS][jpd_pkg::XMAG_W-1:0];
			ang_p1   <= zw[jpd_pkg::ANGU_W-1:0];
			east_p1  <= east_c[NS];
			north_p1 <= north_c[NS];

			// Gain correction split in two partial products.
			ph_p2    <= xmag_p1[jpd_pkg::XMAG_W-1:jpd_pkg::XLO_W] * jpd_pkg::INV_GAIN;
			pl_p2    <= xmag_p1[jpd_pkg::XLO_W-1:0] * jpd_pkg::INV_GAIN;
			hd_p2    <= 32'(ang_p1) * 32'd100;
			east_p2  <= east_p1;
			north_p2 <= north_p1;

			mag_p3   <= (mag_raw > (SUM_W-MSH)'(jpd_pkg::MAG_MAX)) ?
				jpd_pkg::MAG_MAX : mag_raw[jpd_pkg::MAG_W-1:0];
			head_p3  <= (hd_raw > jpd_pkg::HEAD_MAX) ? jpd_pkg::HEAD_MAX : hd_raw;
			east_p3  <= east_p2;
			north_p3 <= north_p2;

			mag_p4   <= cen_nxt ? '0 : mag_p3;
			head_p4  <= cen_nxt ? '0 : head_p3;
			cen_p4   <= cen_nxt;
			dir_p4   <= dir_nxt;
			east_p4  <= east_p3;
			north_p4 <= north_p3;
		end
	end

	assign result_out.valid        = vld_p4;
	assign result_out.east_mapped  = east_p4;
	assign result_out.north_mapped = north_p4;
	assign result_out.magnitude    = mag_p4;
	assign result_out.heading      = head_p4;
	assign result_out.centred      = cen_p4;
	assign result_out.direction    = dir_p4;
endmodule
